// ----- src/rfsab_pkg.sv -----
package rfsab_pkg;

	// Command type codes carried in req_type. Codes above REQ_READ are invalid.
	localparam logic [2:0] REQ_FILL        = 3'd0;
	localparam logic [2:0] REQ_STROKE      = 3'd1;
	localparam logic [2:0] REQ_CLEAR_RECT  = 3'd2;
	localparam logic [2:0] REQ_CLEAR_FRAME = 3'd3;
	localparam logic [2:0] REQ_READ        = 3'd4;

	// Register select: bit 2 of the byte address.
	localparam logic REG_FRAME_WIDTH  = 1'b0;
	localparam logic REG_FRAME_HEIGHT = 1'b1;

	localparam logic [8:0]  FRAME_SIZE_RESET = 9'd256;
	localparam logic [31:0] OPAQUE_BLACK     = 32'hff00_0000;

	typedef struct packed {
		logic [2:0]         req_type;
		logic signed [15:0] rect_left;
		logic signed [15:0] rect_top;
		logic signed [15:0] rect_right;
		logic signed [15:0] rect_bottom;
		logic [11:0]        stroke_width;
		logic [7:0]         color_red;
		logic [7:0]         color_green;
		logic [7:0]         color_blue;
		logic [7:0]         color_alpha;
	} req_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SETUP,
		ST_BASE,
		ST_WALK,
		ST_DRAIN,
		ST_READ,
		ST_DONE
	} state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic latch;
		logic clip;
		logic base;
		logic walk;
		logic rd_issue;
		logic result;
	} ctrl_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic invalid;
		logic read;
		logic in_bounds;
		logic empty;
		logic walk_last;
		logic pipe_idle;
		logic out_free;
	} dp_stat_t;

endpackage

// ----- src/rfsab_ifs.sv -----
interface rfsab_req_if;
	logic               valid;
	logic               ready;
	logic [2:0]         req_type;
	logic signed [15:0] rect_left;
	logic signed [15:0] rect_top;
	logic signed [15:0] rect_right;
	logic signed [15:0] rect_bottom;
	logic [11:0]        stroke_width;
	logic [7:0]         color_red;
	logic [7:0]         color_green;
	logic [7:0]         color_blue;
	logic [7:0]         color_alpha;

	modport source (
		output valid, req_type, rect_left, rect_top, rect_right, rect_bottom,
		output stroke_width, color_red, color_green, color_blue, color_alpha,
		input ready
	);
	modport sink (
		input valid, req_type, rect_left, rect_top, rect_right, rect_bottom,
		input stroke_width, color_red, color_green, color_blue, color_alpha,
		output ready
	);
endinterface

interface rfsab_rsp_if;
	logic        valid;
	logic        ready;
	logic        status;
	logic [31:0] pixel_value;

	modport source (output valid, status, pixel_value, input ready);
	modport sink (input valid, status, pixel_value, output ready);
endinterface

// ----- src/rfsab_ram.sv -----
module rfsab_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 256,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ----- src/rfsab_ctrl.sv -----
module rfsab_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  rfsab_pkg::dp_stat_t   stat,
	output rfsab_pkg::ctrl_cmd_t  cmd
);

	rfsab_pkg::state_t state_q;
	rfsab_pkg::state_t state_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= rfsab_pkg::ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt = state_q;
		cmd       = '0;
		in_ready  = 1'b0;
		case (state_q)
			rfsab_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.latch = 1'b1;
					state_nxt = rfsab_pkg::ST_SETUP;
				end
			end
			rfsab_pkg::ST_SETUP: begin
				cmd.clip  = 1'b1;
				state_nxt = rfsab_pkg::ST_BASE;
			end
			rfsab_pkg::ST_BASE: begin
				cmd.base = 1'b1;
				if (stat.invalid) begin
					state_nxt = rfsab_pkg::ST_DONE;
				end else if (stat.read) begin
					state_nxt = stat.in_bounds ? rfsab_pkg::ST_READ : rfsab_pkg::ST_DONE;
				end else if (stat.empty) begin
					state_nxt = rfsab_pkg::ST_DONE;
				end else begin
					state_nxt = rfsab_pkg::ST_WALK;
				end
			end
			rfsab_pkg::ST_WALK: begin
				cmd.walk = 1'b1;
				if (stat.walk_last) begin
					state_nxt = rfsab_pkg::ST_DRAIN;
				end
			end
			rfsab_pkg::ST_DRAIN: begin
				if (stat.pipe_idle) begin
					state_nxt = rfsab_pkg::ST_DONE;
				end
			end
			rfsab_pkg::ST_READ: begin
				cmd.rd_issue = 1'b1;
				state_nxt    = rfsab_pkg::ST_DONE;
			end
			rfsab_pkg::ST_DONE: begin
				if (stat.out_free) begin
					cmd.result = 1'b1;
					state_nxt  = rfsab_pkg::ST_IDLE;
				end
			end
			default: begin
				state_nxt = rfsab_pkg::ST_IDLE;
			end
		endcase
	end

endmodule

// ----- src/rfsab_dp.sv -----
module rfsab_dp #(
	parameter int MAX_WIDTH  = 256,
	parameter int MAX_HEIGHT = 256
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  rfsab_pkg::req_t       req,
	input  logic [8:0]            frame_width,
	input  logic [8:0]            frame_height,
	input  rfsab_pkg::ctrl_cmd_t  cmd,
	output rfsab_pkg::dp_stat_t   stat,
	output logic                  rsp_valid,
	input  logic                  rsp_ready,
	output logic                  rsp_status,
	output logic [31:0]           rsp_pixel
);

	localparam int XW    = $clog2(MAX_WIDTH + 1);
	localparam int YW    = $clog2(MAX_HEIGHT + 1);
	localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
	localparam int AW    = $clog2(DEPTH);
	localparam int CW    = 18;

	// floor(v / 255) for v below 65536 - 256.
	function automatic logic [7:0] div255(input logic [15:0] v);
		logic [16:0] t;
		t = {1'b0, v} + 17'd1 + {9'd0, v[15:8]};
		return t[15:8];
	endfunction

	function automatic logic signed [CW-1:0] sx(input logic signed [15:0] v);
		return {{(CW-16){v[15]}}, v};
	endfunction

	function automatic logic [CW-1:0] clamp_c(input logic signed [CW-1:0] v,
	                                         input logic signed [CW-1:0] lim);
		logic [CW-1:0] r;
		if (v < 0) begin
			r = '0;
		end else if (v > lim) begin
			r = lim;
		end else begin
			r = v;
		end
		return r;
	endfunction

	// Active frame size, saturated to the store's dimensions.
	logic [XW-1:0] eff_w;
	logic [YW-1:0] eff_h;

	always_comb begin
		if (32'(frame_width) > 32'(MAX_WIDTH)) begin
			eff_w = XW'(MAX_WIDTH);
		end else begin
			eff_w = XW'(frame_width);
		end
		if (32'(frame_height) > 32'(MAX_HEIGHT)) begin
			eff_h = YW'(MAX_HEIGHT);
		end else begin
			eff_h = YW'(frame_height);
		end
	end

	// Captured command.
	logic [2:0]         type_q;
	logic signed [15:0] left_q;
	logic signed [15:0] top_q;
	logic signed [15:0] right_q;
	logic signed [15:0] bottom_q;
	logic [11:0]        stroke_q;
	logic [7:0]         alpha_q;
	logic [15:0]        pr_q;
	logic [15:0]        pg_q;
	logic [15:0]        pb_q;

	always_ff @(posedge clk) begin
		if (cmd.latch) begin
			type_q   <= req.req_type;
			left_q   <= req.rect_left;
			top_q    <= req.rect_top;
			right_q  <= req.rect_right;
			bottom_q <= req.rect_bottom;
			stroke_q <= (req.stroke_width == 12'd0) ? 12'd1 : req.stroke_width;
			alpha_q  <= req.color_alpha;
			pr_q     <= {8'd0, req.color_red} * {8'd0, req.color_alpha} + 16'd127;
			pg_q     <= {8'd0, req.color_green} * {8'd0, req.color_alpha} + 16'd127;
			pb_q     <= {8'd0, req.color_blue} * {8'd0, req.color_alpha} + 16'd127;
		end
	end

	logic is_read;
	logic is_frame;
	logic is_stroke;
	logic is_blend;

	assign is_read   = (type_q == rfsab_pkg::REQ_READ);
	assign is_frame  = (type_q == rfsab_pkg::REQ_CLEAR_FRAME);
	assign is_stroke = (type_q == rfsab_pkg::REQ_STROKE);
	assign is_blend  = (type_q == rfsab_pkg::REQ_FILL) || is_stroke;

	// Clipping and stroke band edges.
	logic signed [CW-1:0] wz;
	logic signed [CW-1:0] hz;
	logic signed [CW-1:0] sz;
	logic signed [CW-1:0] lft_s;
	logic signed [CW-1:0] top_s;
	logic signed [CW-1:0] rgt_s;
	logic signed [CW-1:0] bot_s;
	logic [CW-1:0]        cl_c;
	logic [CW-1:0]        ct_c;
	logic [CW-1:0]        cr_c;
	logic [CW-1:0]        cb_c;

	always_comb begin
		wz    = {{(CW-XW){1'b0}}, eff_w};
		hz    = {{(CW-YW){1'b0}}, eff_h};
		sz    = {{(CW-12){1'b0}}, stroke_q};
		lft_s = sx(left_q);
		top_s = sx(top_q);
		rgt_s = sx(right_q);
		bot_s = sx(bottom_q);
		cl_c  = clamp_c(lft_s, wz);
		ct_c  = clamp_c(top_s, hz);
		cr_c  = clamp_c(rgt_s, wz);
		cb_c  = clamp_c(bot_s, hz);
	end

	logic [XW-1:0]        cl_q;
	logic [YW-1:0]        ct_q;
	logic [XW-1:0]        cr_q;
	logic [YW-1:0]        cb_q;
	logic                 inb_q;
	logic signed [CW-1:0] lband_q;
	logic signed [CW-1:0] rband_q;
	logic signed [CW-1:0] tband_q;
	logic signed [CW-1:0] bband_q;
	logic [31:0]          color_q;

	always_ff @(posedge clk) begin
		if (cmd.clip) begin
			if (is_frame) begin
				cl_q <= '0;
				ct_q <= '0;
				cr_q <= eff_w;
				cb_q <= eff_h;
			end else begin
				cl_q <= cl_c[XW-1:0];
				ct_q <= ct_c[YW-1:0];
				cr_q <= cr_c[XW-1:0];
				cb_q <= cb_c[YW-1:0];
			end
			inb_q   <= (lft_s >= 0) && (top_s >= 0) && (lft_s < wz) && (top_s < hz);
			lband_q <= lft_s + sz;
			rband_q <= rgt_s - sz;
			tband_q <= top_s + sz;
			bband_q <= bot_s - sz;
			color_q <= {alpha_q, div255(pr_q), div255(pg_q), div255(pb_q)};
		end
	end

	// Raster walk over the clipped rectangle.
	logic [XW+YW-1:0] base_prod;
	logic [AW-1:0]    row_base_q;
	logic [XW-1:0]    x_q;
	logic [YW-1:0]    y_q;
	logic [XW-1:0]    x_nx;
	logic [YW-1:0]    y_nx;
	logic             x_end;
	logic             y_end;

	assign base_prod = {{XW{1'b0}}, ct_q} * {{YW{1'b0}}, eff_w};
	assign x_nx      = x_q + XW'(1);
	assign y_nx      = y_q + YW'(1);
	assign x_end     = (x_nx == cr_q);
	assign y_end     = (y_nx == cb_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x_q        <= '0;
			y_q        <= '0;
			row_base_q <= '0;
		end else if (cmd.base) begin
			x_q        <= cl_q;
			y_q        <= ct_q;
			row_base_q <= base_prod[AW-1:0];
		end else if (cmd.walk) begin
			if (x_end) begin
				x_q        <= cl_q;
				y_q        <= y_nx;
				row_base_q <= row_base_q + AW'(eff_w);
			end else begin
				x_q <= x_nx;
			end
		end
	end

	logic [AW-1:0]        pix_addr;
	logic signed [CW-1:0] xs;
	logic signed [CW-1:0] ys;
	logic                 in_band;
	logic                 paint;

	assign pix_addr = row_base_q + AW'(x_q);
	assign xs       = {{(CW-XW){1'b0}}, x_q};
	assign ys       = {{(CW-YW){1'b0}}, y_q};
	assign in_band  = (xs < lband_q) || (xs >= rband_q) || (ys < tband_q) || (ys >= bband_q);
	assign paint    = is_stroke ? in_band : 1'b1;

	// Read-modify-write pipeline: issue, multiply, blend and write.
	logic          v_s1;
	logic          v_s2;
	logic [AW-1:0] addr_s1;
	logic [AW-1:0] addr_s2;
	logic          we_s1;
	logic          we_s2;
	logic          blend_s1;
	logic          blend_s2;
	logic          black_s1;
	logic          black_s2;
	logic [3:0][15:0] prod_s2;
	logic [31:0]   rd_data;
	logic [7:0]    inv_a;
	logic [31:0]   wr_data;

	assign inv_a = 8'hff - color_q[31:24];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			v_s1 <= cmd.walk;
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		addr_s1  <= pix_addr;
		we_s1    <= paint;
		blend_s1 <= is_blend;
		black_s1 <= is_frame;
		addr_s2  <= addr_s1;
		we_s2    <= we_s1;
		blend_s2 <= blend_s1;
		black_s2 <= black_s1;
		for (int k = 0; k < 4; k++) begin
			prod_s2[k] <= {8'd0, rd_data[8*k +: 8]} * {8'd0, inv_a} + 16'd127;
		end
	end

	always_comb begin
		logic [8:0] sum;
		wr_data = '0;
		sum     = '0;
		if (blend_s2) begin
			for (int k = 0; k < 4; k++) begin
				sum = {1'b0, color_q[8*k +: 8]} + {1'b0, div255(prod_s2[k])};
				wr_data[8*k +: 8] = sum[8] ? 8'hff : sum[7:0];
			end
		end else if (black_s2) begin
			wr_data = rfsab_pkg::OPAQUE_BLACK;
		end
	end

	rfsab_ram #(
		.WIDTH (32),
		.DEPTH (DEPTH)
	) u_store (
		.clk   (clk),
		.we    (v_s2 && we_s2),
		.waddr (addr_s2),
		.wdata (wr_data),
		.re    (cmd.walk || cmd.rd_issue),
		.raddr (pix_addr),
		.rdata (rd_data)
	);

	// Result register.
	logic        rsp_valid_q;
	logic        status_q;
	logic [31:0] pixel_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (cmd.result) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.result) begin
			status_q <= stat.invalid;
			pixel_q  <= (is_read && inb_q) ? rd_data : 32'd0;
		end
	end

	assign rsp_valid  = rsp_valid_q;
	assign rsp_status = status_q;
	assign rsp_pixel  = pixel_q;

	always_comb begin
		stat           = '0;
		stat.invalid   = (type_q > rfsab_pkg::REQ_READ);
		stat.read      = is_read;
		stat.in_bounds = inb_q;
		stat.empty     = !((cr_q > cl_q) && (cb_q > ct_q));
		stat.walk_last = x_end && y_end;
		stat.pipe_idle = !v_s1 && !v_s2;
		stat.out_free  = !rsp_valid_q || rsp_ready;
	end

endmodule

// ----- src/rect_fill_stroke_alpha_blitter.sv -----
// Rectangle drawing engine over an ARGB8888 frame store of MAX_WIDTH x MAX_HEIGHT
// words. Each request transaction carries a command: source-over fill, border stroke,
// clear of a rectangle to zero, clear of the whole active frame to opaque black, or
// read of one pixel; every request produces exactly one response transaction with a
// status (1 for an unknown command type) and the pixel read (zero for all other
// commands). Rectangles are clipped to the active frame set by the frame_width and
// frame_height registers (APB, byte addresses 0 and 4; values above the store size
// saturate). Colors arrive as straight channels and are premultiplied with rounding.
// A draw or clear command walks every pixel of the clipped rectangle (the whole
// active frame for a frame clear); no new request is accepted until its response
// has been registered; reads and invalid or empty commands skip the walk.
// The one-pixel-per-cycle pace is set by the read-modify-write
// pipeline on the frame store, which has one read port and one write port. A
// finished response waits in an output register, so the next request is taken while
// it is still pending. The frame store needs no initialization; reading a pixel that
// was never written returns an unspecified value.
module rect_fill_stroke_alpha_blitter #(
	parameter int MAX_WIDTH  = 256,
	parameter int MAX_HEIGHT = 256
) (
	input  logic        clk,
	input  logic        arst_n,
	rfsab_req_if.sink   req,
	rfsab_rsp_if.source rsp,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	// Configuration registers. Only bit 2 of the byte address selects the register;
	// the low address bits are ignored as usual for word-wide registers.
	logic [8:0] frame_width_q;
	logic [8:0] frame_height_q;
	logic       cfg_wr;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_width_q  <= rfsab_pkg::FRAME_SIZE_RESET;
			frame_height_q <= rfsab_pkg::FRAME_SIZE_RESET;
		end else if (cfg_wr) begin
			if (paddr[2] == rfsab_pkg::REG_FRAME_HEIGHT) begin
				frame_height_q <= pwdata[8:0];
			end else begin
				frame_width_q <= pwdata[8:0];
			end
		end
	end

	always_comb begin
		if (paddr[2] == rfsab_pkg::REG_FRAME_WIDTH) begin
			prdata = {23'd0, frame_width_q};
		end else begin
			prdata = {23'd0, frame_height_q};
		end
	end

	// Request payload gathered into one struct for the datapath.
	rfsab_pkg::req_t req_s;

	always_comb begin
		req_s.req_type     = req.req_type;
		req_s.rect_left    = req.rect_left;
		req_s.rect_top     = req.rect_top;
		req_s.rect_right   = req.rect_right;
		req_s.rect_bottom  = req.rect_bottom;
		req_s.stroke_width = req.stroke_width;
		req_s.color_red    = req.color_red;
		req_s.color_green  = req.color_green;
		req_s.color_blue   = req.color_blue;
		req_s.color_alpha  = req.color_alpha;
	end

	rfsab_pkg::ctrl_cmd_t cmd;
	rfsab_pkg::dp_stat_t  stat;
	logic                 in_ready;

	assign req.ready = in_ready;

	// The controller sequences setup, the raster walk, the pipeline drain and the
	// response; the datapath owns the frame store and all arithmetic.
	rfsab_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (req.valid),
		.in_ready (in_ready),
		.stat     (stat),
		.cmd      (cmd)
	);

	rfsab_dp #(
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_HEIGHT (MAX_HEIGHT)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.req          (req_s),
		.frame_width  (frame_width_q),
		.frame_height (frame_height_q),
		.cmd          (cmd),
		.stat         (stat),
		.rsp_valid    (rsp.valid),
		.rsp_ready    (rsp.ready),
		.rsp_status   (rsp.status),
		.rsp_pixel    (rsp.pixel_value)
	);

endmodule
